[rtl/icf_pkg.sv]
`default_nettype none
package icf_pkg;

    // Input item kinds carried in tuser.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_DRAIN  = 1'b1;

    // Kernel choices.
    localparam logic [1:0] MODE_BOX     = 2'd0;
    localparam logic [1:0] MODE_LAPLACE = 2'd1;
    localparam logic [1:0] MODE_SHARPEN = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_FILTER_MODE  = 3'd0;
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd1;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd2;
    localparam logic [2:0] REG_MAX_COLOR    = 3'd3;
    localparam logic [2:0] REG_COLOR_MODE   = 3'd4;

    // Reciprocal of 9 scaled by 2^23, exact for sums below 2^20.
    localparam logic [19:0] RECIP9       = 20'd932068;
    localparam int          RECIP9_SHIFT = 23;

    // One column of the 3x3 window, top row first.
    typedef struct packed {
        logic [15:0] top;
        logic [15:0] mid;
        logic [15:0] bot;
    } column_t;

    // Per-request control carried from the input stage to the window stage.
    typedef struct packed {
        logic have;    // request produces a result
        logic row0_ok; // row above lies inside the frame
        logic row2_ok; // row below lies inside the frame
        logic col0_ok; // left column lies inside the frame
        logic col2_ok; // right column lies inside the frame
        logic last;    // final result of the frame
    } tap_ctrl_t;

endpackage
`default_nettype wire

[rtl/icf_tap_cell.sv]
`default_nettype none
// One window column cell: takes its neighbor's column on every shift.
module icf_tap_cell (
    input  wire              aclk,
    input  wire              shift,
    input  icf_pkg::column_t col_in,
    output icf_pkg::column_t col_out
);

    icf_pkg::column_t col_reg;
    icf_pkg::column_t col_next;

    always_comb begin
        col_next = shift ? col_in : col_reg;
    end

    always_ff @(posedge aclk) begin
        col_reg <= col_next;
    end

    assign col_out = col_reg;

endmodule
`default_nettype wire

[rtl/image_conv3x3_filter_core.sv]
`default_nettype none
// Streaming 3x3 convolution (box blur, Laplace or sharpen) on a raster image with one grey or
// three interleaved RGB channels. One request is accepted per clock while the result side keeps
// up; each result is completed by the request one row plus one pixel of samples after the
// sample at its own position; the output is registered. Feed drain requests after the last
// sample to push out the tail; the final result carries tlast. Geometry is taken at frame start.
// The window is a chain of six column cells fed by two row memories of MAX_WIDTH*3 samples.
module image_conv3x3_filter_core #(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  wire         aclk,
    input  wire         aresetn,
    // Configuration write channel.
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [2:0]  cfg_index,
    input  wire  [15:0] cfg_data,
    // Input stream.
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // [15:0] sample
    input  wire         s_tuser,   // [0] cmd
    // Result stream.
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // [15:0] value
    output logic        m_tlast
);

    localparam int XW    = $clog2(MAX_WIDTH + 1);
    localparam int YW    = $clog2(MAX_HEIGHT + 1);
    localparam int CW    = (XW > 11) ? XW : 11;
    localparam int CH    = (YW > 11) ? YW : 11;
    localparam int DEPTH = MAX_WIDTH * 3;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(3 * (MAX_WIDTH + 1) + 1);
    localparam logic [15:0] SMASK = 16'((32'd1 << SAMPLE_BITS) - 32'd1);

    // Configuration registers.
    logic [1:0]  filter_mode_reg;
    logic [10:0] image_width_reg;
    logic [10:0] image_height_reg;
    logic [15:0] max_color_reg;
    logic        color_mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_mode_reg  <= icf_pkg::MODE_BOX;
            image_width_reg  <= 11'd1;
            image_height_reg <= 11'd1;
            max_color_reg    <= 16'd255;
            color_mode_reg   <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                icf_pkg::REG_FILTER_MODE:  filter_mode_reg  <= cfg_data[1:0];
                icf_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[10:0];
                icf_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[10:0];
                icf_pkg::REG_MAX_COLOR:    max_color_reg    <= cfg_data;
                icf_pkg::REG_COLOR_MODE:   color_mode_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Frame and position state.
    logic          run_reg, run_next;
    logic [XW-1:0] fw_reg, fw_next;
    logic [YW-1:0] fh_reg, fh_next;
    logic          rgb_reg, rgb_next;
    logic [1:0]    ic_reg, ic_next;
    logic [XW-1:0] ix_reg, ix_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [YW-1:0] iy_reg, iy_next;
    logic          done_reg, done_next;
    logic [LW-1:0] lag_reg, lag_next;
    logic [1:0]    oc_reg, oc_next;
    logic [XW-1:0] ox_reg, ox_next;
    logic [YW-1:0] oy_reg, oy_next;

    // Pipeline control.
    logic                s1_valid_reg;
    icf_pkg::tap_ctrl_t  s1_ctrl_reg;
    logic [AW-1:0]       s1_idx_reg;
    logic [15:0]         s1_s_reg;
    logic [15:0]         rd_a_reg, rd_b_reg;
    logic                fwd_reg;
    logic [15:0]         fwd_a_reg, fwd_b_reg;
    logic                s2_valid_reg;
    logic                s2_last_reg;
    logic [1:0]          s2_mode_reg;
    logic signed [20:0]  s2_sum_reg;
    logic                m_tvalid_reg;
    logic [15:0]         m_tdata_reg;
    logic                m_tlast_reg;

    logic en, acc, eff, s1_fire;
    logic [CW-1:0] w_wide;
    logic [CH-1:0] h_wide;
    logic [XW-1:0] g_w;
    logic [YW-1:0] g_h;
    logic          g_rgb;
    logic [1:0]    g_clast;
    logic [1:0]    ic_cur, oc_cur;
    logic [XW-1:0] ix_cur, ox_cur;
    logic [AW-1:0] idx_cur;
    logic [YW-1:0] iy_cur, oy_cur;
    logic          done_cur;
    logic [LW-1:0] lag_cur, lag_base;
    logic          have, row_wrap, ch_wrap, out_last, och_wrap, orow_wrap;
    icf_pkg::tap_ctrl_t ctrl_new;
    logic [15:0]   a_eff, b_eff;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign acc      = s_tvalid && en;
    assign eff      = acc && (s_tuser == icf_pkg::CMD_SAMPLE || (run_reg && done_reg));
    assign s1_fire  = en && s1_valid_reg;

    // Geometry: latched while a frame runs, saturated configuration at frame start.
    always_comb begin
        w_wide = CW'(image_width_reg);
        h_wide = CH'(image_height_reg);
        if (run_reg) begin
            g_w   = fw_reg;
            g_h   = fh_reg;
            g_rgb = rgb_reg;
        end else begin
            if (w_wide == '0)                 g_w = XW'(1);
            else if (w_wide > CW'(MAX_WIDTH)) g_w = XW'(MAX_WIDTH);
            else                              g_w = XW'(w_wide);
            if (h_wide == '0)                  g_h = YW'(1);
            else if (h_wide > CH'(MAX_HEIGHT)) g_h = YW'(MAX_HEIGHT);
            else                               g_h = YW'(h_wide);
            g_rgb = color_mode_reg;
        end
        g_clast  = g_rgb ? 2'd2 : 2'd0;
        lag_base = LW'(g_w) + LW'(1);
        if (g_rgb) lag_base = lag_base + (lag_base << 1);
    end

    // Position counters, advanced on every effective request.
    always_comb begin
        ic_cur   = run_reg ? ic_reg   : 2'd0;
        ix_cur   = run_reg ? ix_reg   : '0;
        idx_cur  = run_reg ? idx_reg  : '0;
        iy_cur   = run_reg ? iy_reg   : '0;
        done_cur = run_reg ? done_reg : 1'b0;
        lag_cur  = run_reg ? lag_reg  : lag_base;
        oc_cur   = run_reg ? oc_reg   : 2'd0;
        ox_cur   = run_reg ? ox_reg   : '0;
        oy_cur   = run_reg ? oy_reg   : '0;

        have     = (lag_cur == '0);
        ch_wrap  = (ic_cur == g_clast);
        row_wrap = ch_wrap && (ix_cur == g_w - XW'(1));

        ic_next  = ch_wrap ? 2'd0 : ic_cur + 2'd1;
        ix_next  = ch_wrap ? (row_wrap ? '0 : ix_cur + XW'(1)) : ix_cur;
        idx_next = row_wrap ? '0 : idx_cur + AW'(1);
        iy_next  = row_wrap ? iy_cur + YW'(1) : iy_cur;
        done_next = done_cur || (row_wrap && iy_cur == g_h - YW'(1));
        lag_next = have ? '0 : lag_cur - LW'(1);

        och_wrap  = (oc_cur == g_clast);
        orow_wrap = och_wrap && (ox_cur == g_w - XW'(1));
        oc_next = oc_cur;
        ox_next = ox_cur;
        oy_next = oy_cur;
        if (have) begin
            oc_next = och_wrap ? 2'd0 : oc_cur + 2'd1;
            ox_next = och_wrap ? (orow_wrap ? '0 : ox_cur + XW'(1)) : ox_cur;
            oy_next = orow_wrap ? oy_cur + YW'(1) : oy_cur;
        end
        out_last = have && orow_wrap && (oy_cur == g_h - YW'(1));

        ctrl_new.have    = have;
        ctrl_new.row0_ok = (oy_cur != '0);
        ctrl_new.row2_ok = (oy_cur != g_h - YW'(1));
        ctrl_new.col0_ok = (ox_cur != '0);
        ctrl_new.col2_ok = (ox_cur != g_w - XW'(1));
        ctrl_new.last    = out_last;

        run_next = !out_last;
        fw_next  = g_w;
        fh_next  = g_h;
        rgb_next = g_rgb;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            ic_reg   <= 2'd0;
            ix_reg   <= '0;
            idx_reg  <= '0;
            iy_reg   <= '0;
            done_reg <= 1'b0;
            lag_reg  <= '0;
            oc_reg   <= 2'd0;
            ox_reg   <= '0;
            oy_reg   <= '0;
            fw_reg   <= XW'(1);
            fh_reg   <= YW'(1);
            rgb_reg  <= 1'b0;
        end else if (eff) begin
            run_reg  <= run_next;
            ic_reg   <= ic_next;
            ix_reg   <= ix_next;
            idx_reg  <= idx_next;
            iy_reg   <= iy_next;
            done_reg <= done_next;
            lag_reg  <= lag_next;
            oc_reg   <= oc_next;
            ox_reg   <= ox_next;
            oy_reg   <= oy_next;
            fw_reg   <= fw_next;
            fh_reg   <= fh_next;
            rgb_reg  <= rgb_next;
        end
    end

    // Row memories: read on accept, written back when the request leaves the window stage.
    logic [15:0] upper_mem [DEPTH];
    logic [15:0] middle_mem [DEPTH];

    assign a_eff = fwd_reg ? fwd_a_reg : rd_a_reg;
    assign b_eff = fwd_reg ? fwd_b_reg : rd_b_reg;

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            upper_mem[s1_idx_reg]  <= b_eff;
            middle_mem[s1_idx_reg] <= s1_s_reg;
        end
        if (eff) begin
            rd_a_reg   <= upper_mem[idx_cur];
            rd_b_reg   <= middle_mem[idx_cur];
            fwd_a_reg  <= b_eff;
            fwd_b_reg  <= s1_s_reg;
            s1_idx_reg <= idx_cur;
            s1_s_reg   <= done_cur ? 16'd0 : (s_tdata & SMASK);
            s1_ctrl_reg <= ctrl_new;
        end
    end

    // Same-address write in flight bypasses the memory read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else if (eff) begin
            fwd_reg <= s1_fire && (s1_idx_reg == idx_cur);
        end
    end

    // Window: chain of column cells, newest column at the head.
    icf_pkg::column_t new_col;
    icf_pkg::column_t cell_col [6];

    assign new_col = '{top: a_eff, mid: b_eff, bot: s1_s_reg};

    genvar gi;
    generate
        for (gi = 0; gi < 6; gi++) begin : g_cell
            icf_tap_cell u_cell (
                .aclk    (aclk),
                .shift   (s1_fire),
                .col_in  ((gi == 0) ? new_col : cell_col[(gi == 0) ? 0 : gi - 1]),
                .col_out (cell_col[gi])
            );
        end
    endgenerate

    // Kernel sums over the masked taps.
    icf_pkg::column_t lc, cc, rc;
    logic [15:0] t00, t01, t02, t10, t11, t12, t20, t21, t22;
    logic [19:0] box_sum;
    logic [17:0] cross_sum;
    logic signed [20:0] sum_sel;
    logic [1:0] mode_eff;

    always_comb begin
        lc = rgb_reg ? cell_col[5] : cell_col[1];
        cc = rgb_reg ? cell_col[2] : cell_col[0];
        rc = new_col;
        t00 = (s1_ctrl_reg.row0_ok && s1_ctrl_reg.col0_ok) ? lc.top : 16'd0;
        t01 =  s1_ctrl_reg.row0_ok                         ? cc.top : 16'd0;
        t02 = (s1_ctrl_reg.row0_ok && s1_ctrl_reg.col2_ok) ? rc.top : 16'd0;
        t10 =  s1_ctrl_reg.col0_ok                         ? lc.mid : 16'd0;
        t11 = cc.mid;
        t12 =  s1_ctrl_reg.col2_ok                         ? rc.mid : 16'd0;
        t20 = (s1_ctrl_reg.row2_ok && s1_ctrl_reg.col0_ok) ? lc.bot : 16'd0;
        t21 =  s1_ctrl_reg.row2_ok                         ? cc.bot : 16'd0;
        t22 = (s1_ctrl_reg.row2_ok && s1_ctrl_reg.col2_ok) ? rc.bot : 16'd0;
        box_sum = 20'(t00) + 20'(t01) + 20'(t02) + 20'(t10) + 20'(t11)
                + 20'(t12) + 20'(t20) + 20'(t21) + 20'(t22);
        cross_sum = 18'(t01) + 18'(t10) + 18'(t12) + 18'(t21);
        mode_eff = filter_mode_reg;
        case (filter_mode_reg)
            icf_pkg::MODE_LAPLACE:
                sum_sel = $signed({3'b000, t11, 2'b00}) - $signed({3'b000, cross_sum});
            icf_pkg::MODE_SHARPEN:
                sum_sel = $signed({3'b000, t11, 2'b00}) + $signed({5'b00000, t11})
                        - $signed({3'b000, cross_sum});
            default: begin
                sum_sel  = $signed({1'b0, box_sum});
                mode_eff = icf_pkg::MODE_BOX;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= eff;
            s2_valid_reg <= s1_valid_reg && s1_ctrl_reg.have;
            m_tvalid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            s2_sum_reg  <= sum_sel;
            s2_mode_reg <= mode_eff;
            s2_last_reg <= s1_ctrl_reg.last;
        end
    end

    // Box sums are divided by nine through the reciprocal; every result is then clamped.
    logic [39:0] div_prod;
    logic [19:0] div_q;
    logic [20:0] mag;
    logic [15:0] lim, clamped;

    always_comb begin
        div_prod = 40'(s2_sum_reg[19:0]) * 40'(icf_pkg::RECIP9);
        div_q    = 20'(div_prod >> icf_pkg::RECIP9_SHIFT);
        mag      = (s2_mode_reg == icf_pkg::MODE_BOX) ? {1'b0, div_q} : s2_sum_reg;
        lim      = (max_color_reg > SMASK) ? SMASK : max_color_reg;
        if (mag[20])                      clamped = 16'd0;
        else if (mag[19:0] > 20'(lim))    clamped = lim;
        else                              clamped = mag[15:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= clamped;
            m_tlast_reg <= s2_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
`default_nettype wire
